// ===== rtl/core/khs_pkg.sv =====
// ----------------------------------------------------------------------------
// khs_pkg
// shared types, codes and sizes for the key hash set
// ----------------------------------------------------------------------------
package khs_pkg;

    localparam int KEY_W       = 64;
    localparam int CNT_W       = 11;
    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_WAYS    = 4;

    // modulo unit: bits retired per cycle and digit steps per key
    localparam int DIGIT_W   = 8;
    localparam int DIV_STEPS = KEY_W / DIGIT_W;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [CNT_W-1:0] RESET_BUCKET_COUNT = 11'd1024;

    // request actions
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    // result status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic found;
        logic status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/khs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// khs_mod_unit
// iterative 64-bit modulo by an 11-bit divisor, one digit per cycle
// ----------------------------------------------------------------------------
module khs_mod_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [khs_pkg::KEY_W-1:0] dividend,
    input  logic [khs_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [khs_pkg::CNT_W-1:0] rem
);
    import khs_pkg::*;

    logic [KEY_W-1:0]  num_reg;
    logic [KEY_W-1:0]  num_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    acc;

    // restoring steps over one digit of the dividend
    always_comb
    begin
        acc = {1'b0, rem_reg};
        for (int i = 0; i < DIGIT_W; i++)
        begin
            acc = {acc[CNT_W-1:0], num_reg[KEY_W-1-i]};
            if (acc >= {1'b0, div_reg})
            begin
                acc = acc - {1'b0, div_reg};
            end
        end
        rem_next = acc[CNT_W-1:0];
        num_next = num_reg << DIGIT_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/khs_store.sv =====
// ----------------------------------------------------------------------------
// khs_store
// bucket rows: valid bits and keys, registered read, clearing pass after reset
// ----------------------------------------------------------------------------
module khs_store #(
    parameter int BUCKETS = khs_pkg::DEF_BUCKETS,
    parameter int WAYS    = khs_pkg::DEF_WAYS,
    parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_en,
    input  logic [BW-1:0]                        rd_addr,
    output logic [WAYS-1:0]                      rd_valid,
    output logic [WAYS-1:0][khs_pkg::KEY_W-1:0]  rd_keys,
    input  logic                                 wr_en,
    input  logic [BW-1:0]                        wr_addr,
    input  logic [WAYS-1:0]                      wr_valid,
    input  logic [WAYS-1:0]                      wr_way,
    input  logic [khs_pkg::KEY_W-1:0]            wr_key,
    output logic                                 clear_done
);
    import khs_pkg::*;

    logic [WAYS-1:0]             valid_mem [BUCKETS];
    logic [WAYS-1:0][KEY_W-1:0]  key_mem [BUCKETS];

    logic                        clr_busy_reg;
    logic [BW-1:0]               clr_idx_reg;
    logic [WAYS-1:0]             rd_valid_reg;
    logic [WAYS-1:0][KEY_W-1:0]  rd_keys_reg;

    // clearing pass, one row per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == BW'(BUCKETS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            valid_mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            valid_mem[wr_addr] <= wr_valid;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (wr_en && wr_way[w])
            begin
                key_mem[wr_addr][w] <= wr_key;
            end
        end
        if (rd_en)
        begin
            rd_keys_reg <= key_mem[rd_addr];
        end
    end

    assign rd_valid   = rd_valid_reg;
    assign rd_keys    = rd_keys_reg;
    assign clear_done = !clr_busy_reg;

endmodule

// ===== rtl/core/key_hash_set.sv =====
// ----------------------------------------------------------------------------
// key_hash_set: request taken in idle, hashed by the modulo unit, row read,
// row updated, result registered; one request in flight, another taken once it loads
// after reset the valid store is swept row by row, requests stalled
// ----------------------------------------------------------------------------
module key_hash_set #(
    parameter int BUCKETS = khs_pkg::DEF_BUCKETS,
    parameter int WAYS    = khs_pkg::DEF_WAYS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      req_valid,
    output logic                      req_stall,
    input  khs_pkg::req_t             req,
    // result channel
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output khs_pkg::rsp_t             rsp,
    // bucket count register write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [khs_pkg::CNT_W-1:0] cfg_data
);
    import khs_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    // control state
    state_t                      state_reg;
    state_t                      state_next;
    logic [CNT_W-1:0]            bucket_count_reg;
    logic                        rsp_valid_reg;

    // request being worked on
    logic [1:0]                  action_reg;
    logic [KEY_W-1:0]            key_reg;
    logic                        found_reg;
    logic                        found_next;
    logic                        status_reg;
    logic                        status_next;
    rsp_t                        rsp_reg;

    // fsm outputs
    logic                        req_take;
    logic                        div_start;
    logic                        rd_en;
    logic                        upd_en;
    logic                        rsp_load;
    logic                        rsp_free;

    // hash and store interface
    logic [CNT_W-1:0]            divisor;
    logic                        div_done;
    logic [CNT_W-1:0]            div_rem;
    logic [BW-1:0]               bucket;
    logic [WAYS-1:0]             rd_valid;
    logic [WAYS-1:0][KEY_W-1:0]  rd_keys;
    logic                        wr_en;
    logic [WAYS-1:0]             wr_valid;
    logic [WAYS-1:0]             wr_way;
    logic                        clear_done;

    // row update terms
    logic [WAYS-1:0]             hit;
    logic [WAYS-1:0]             free;
    logic [WAYS-1:0]             first_free;

    // effective bucket count: zero acts as one, saturates at BUCKETS
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            divisor = CNT_W'(1);
        end
        else if (32'(bucket_count_reg) > 32'(BUCKETS))
        begin
            divisor = CNT_W'(BUCKETS);
        end
        else
        begin
            divisor = bucket_count_reg;
        end
    end

    // the remainder is below BUCKETS, so the resize loses nothing
    assign bucket = BW'(div_rem);

    khs_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.key),
        .divisor  (divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    khs_store #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .BW      (BW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (bucket),
        .rd_valid   (rd_valid),
        .rd_keys    (rd_keys),
        .wr_en      (wr_en),
        .wr_addr    (bucket),
        .wr_valid   (wr_valid),
        .wr_way     (wr_way),
        .wr_key     (key_reg),
        .clear_done (clear_done)
    );

    // slot compare against the row read back from the store
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit[w] = rd_valid[w] && (rd_keys[w] == key_reg);
        end
        free       = ~rd_valid;
        first_free = free & (~free + 1'b1);
    end

    // modify step of the row rmw, only one request is in flight so the
    // read of the next request always sees this write
    always_comb
    begin
        wr_en       = 1'b0;
        wr_valid    = rd_valid;
        wr_way      = '0;
        found_next  = 1'b0;
        status_next = STATUS_DONE;
        case (action_reg)
            ACT_INSERT:
            begin
                if (free != '0)
                begin
                    wr_en    = upd_en;
                    wr_valid = rd_valid | first_free;
                    wr_way   = first_free;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            ACT_REMOVE:
            begin
                wr_en      = upd_en;
                wr_valid   = rd_valid & ~hit;
                found_next = (hit != '0);
            end
            ACT_LOOKUP:
            begin
                found_next = (hit != '0);
            end
            default:
            begin
                // unused action code: no change, plain done result
                found_next = 1'b0;
            end
        endcase
    end

    // output register frees when empty or being taken this cycle
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        req_take  = 1'b0;
        div_start = 1'b0;
        rd_en     = 1'b0;
        upd_en    = 1'b0;
        rsp_load  = 1'b0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                req_take  = req_valid;
                div_start = req_valid;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_UPDATE:
            begin
                upd_en = 1'b1;
            end
            ST_OUT:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            bucket_count_reg <= RESET_BUCKET_COUNT;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                bucket_count_reg <= cfg_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload holding registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            action_reg <= req.action;
            key_reg    <= req.key;
        end
        if (upd_en)
        begin
            found_reg  <= found_next;
            status_reg <= status_next;
        end
        if (rsp_load)
        begin
            rsp_reg.found  <= found_reg;
            rsp_reg.status <= status_reg;
        end
    end

    // register write always taken, one beat per cycle
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
